FILE: rtl/core/lcp_pkg.sv
// ----------------------------------------------------------------------------
// lcp_pkg
// Shared types and constants for the segment clip and projection pipeline.
// ----------------------------------------------------------------------------
package lcp_pkg;

    // camera space point
    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } lcp_vec_t;

    // quotient bits produced by the divider (bits 32 down to 0)
    localparam int DIV_STEPS = 33;
    // scaled divide: product, magnitude, rounding add, division steps, result
    localparam int MD_LAT    = DIV_STEPS + 4;
    // endpoint transform: subtract, multiply, sum and shift
    localparam int XFORM_LAT = 3;
    // clip stage: select, scaled divide, merge
    localparam int CLIP_LAT  = MD_LAT + 2;

    localparam int FAR_STEP  = 32'hFFFE;

    // configuration register indexes
    localparam logic [2:0] REG_CAMERA_X     = 3'd0;
    localparam logic [2:0] REG_CAMERA_Y     = 3'd1;
    localparam logic [2:0] REG_CAMERA_Z     = 3'd2;
    localparam logic [2:0] REG_ROTATION     = 3'd3;
    localparam logic [2:0] REG_PLANE_DIST   = 3'd4;
    localparam logic [2:0] REG_HALF_WIDTH   = 3'd5;
    localparam logic [2:0] REG_HALF_HEIGHT  = 3'd6;
    localparam logic [2:0] REG_SCROLL       = 3'd7;

endpackage

FILE: rtl/core/lcp_delay.sv
// ----------------------------------------------------------------------------
// lcp_delay
// Enabled shift line that carries side data alongside the pipeline.
// ----------------------------------------------------------------------------
module lcp_delay #(
    parameter int W = 8,
    parameter int N = 4
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         en,
    input  logic [W-1:0] din,
    output logic [W-1:0] dout
);
    logic [W-1:0] tap_reg [N];

    // shift one place per enabled cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < N; i++) tap_reg[i] <= '0;
        end else if (en) begin
            tap_reg[0] <= din;
            for (int i = 1; i < N; i++) tap_reg[i] <= tap_reg[i-1];
        end
    end

    assign dout = tap_reg[N-1];
endmodule

FILE: rtl/core/lcp_muldiv.sv
// ----------------------------------------------------------------------------
// lcp_muldiv
// Pipelined rounded a*b/c over a 64-bit product, -1 on zero divisor or overflow.
// ----------------------------------------------------------------------------
module lcp_muldiv (
    input  logic               aclk,
    input  logic               en,
    input  logic signed [31:0] a,
    input  logic signed [31:0] b,
    input  logic signed [31:0] c,
    output logic signed [31:0] q
);
    import lcp_pkg::*;

    logic signed [63:0] prod_reg;
    logic signed [31:0] c_reg;
    logic [63:0]        ap_reg;
    logic [31:0]        ac_reg;
    logic               neg_reg;
    logic               cz_reg;
    logic [63:0]        ap_next;
    logic [31:0]        ac_next;
    logic [63:0]        num_next;

    logic [31:0] rem_reg [DIV_STEPS+1];
    logic [63:0] num_reg [DIV_STEPS+1];
    logic [32:0] quo_reg [DIV_STEPS+1];
    logic [31:0] dv_reg  [DIV_STEPS+1];
    logic        neg_p_reg [DIV_STEPS+1];
    logic        bad_p_reg [DIV_STEPS+1];

    logic [31:0] rem_next [DIV_STEPS+1];
    logic [32:0] quo_next [DIV_STEPS+1];
    logic [32:0] trial    [DIV_STEPS+1];
    logic        ge       [DIV_STEPS+1];

    logic [32:0]        qf;
    logic [32:0]        qneg;
    logic signed [31:0] q_next;
    logic signed [31:0] q_reg;

    // magnitudes and rounding bias
    always_comb begin
        ap_next  = prod_reg[63] ? 64'(-prod_reg) : 64'(prod_reg);
        ac_next  = c_reg[31] ? 32'(-c_reg) : 32'(c_reg);
        num_next = ap_reg + {33'd0, ac_reg[31:1]};
    end

    // one quotient bit per stage, most significant first
    always_comb begin
        rem_next[0] = {1'b0, num_next[63:33]};
        quo_next[0] = '0;
        trial[0]    = '0;
        ge[0]       = 1'b0;
        for (int i = 1; i <= DIV_STEPS; i++) begin
            trial[i]    = {rem_reg[i-1], num_reg[i-1][DIV_STEPS-i]};
            ge[i]       = trial[i] >= {1'b0, dv_reg[i-1]};
            rem_next[i] = ge[i] ? 32'(trial[i] - {1'b0, dv_reg[i-1]}) : trial[i][31:0];
            quo_next[i] = {quo_reg[i-1][31:0], ge[i]};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= 64'(a) * 64'(b);
            c_reg    <= c;
            ap_reg   <= ap_next;
            ac_reg   <= ac_next;
            neg_reg  <= prod_reg[63] ^ c_reg[31];
            cz_reg   <= (c_reg == 32'sd0);
            rem_reg[0]   <= rem_next[0];
            num_reg[0]   <= num_next;
            quo_reg[0]   <= quo_next[0];
            dv_reg[0]    <= ac_reg;
            neg_p_reg[0] <= neg_reg;
            // quotient of 2^33 or more is an overflow in any case
            bad_p_reg[0] <= cz_reg || ({1'b0, num_next[63:33]} >= ac_reg);
            for (int i = 1; i <= DIV_STEPS; i++) begin
                rem_reg[i]   <= rem_next[i];
                num_reg[i]   <= num_reg[i-1];
                quo_reg[i]   <= quo_next[i];
                dv_reg[i]    <= dv_reg[i-1];
                neg_p_reg[i] <= neg_p_reg[i-1];
                bad_p_reg[i] <= bad_p_reg[i-1];
            end
            q_reg <= q_next;
        end
    end

    // sign and range of the quotient
    always_comb begin
        qf   = quo_reg[DIV_STEPS];
        qneg = 33'(-qf);
        if (bad_p_reg[DIV_STEPS]) begin
            q_next = -32'sd1;
        end else if (neg_p_reg[DIV_STEPS]) begin
            q_next = (qf > 33'h080000000) ? -32'sd1 : $signed(qneg[31:0]);
        end else begin
            q_next = (qf > 33'h07FFFFFFF) ? -32'sd1 : $signed(qf[31:0]);
        end
    end

    assign q = q_reg;
endmodule

FILE: rtl/core/lcp_xform.sv
// ----------------------------------------------------------------------------
// lcp_xform
// Endpoint lane: world point to camera space, translate then rotate.
// ----------------------------------------------------------------------------
module lcp_xform #(
    parameter int TRIG_SHIFT = 10
) (
    input  logic               aclk,
    input  logic               en,
    input  logic signed [31:0] wx,
    input  logic signed [31:0] wy,
    input  logic signed [31:0] wz,
    input  logic signed [31:0] cam_x,
    input  logic signed [31:0] cam_y,
    input  logic signed [31:0] cam_z,
    input  logic [31:0]        rot,
    output lcp_pkg::lcp_vec_t  p
);
    import lcp_pkg::*;

    logic signed [31:0] dx_reg, dy_reg, dz_reg, dz2_reg;
    logic signed [47:0] xc_reg, ys_reg, yc_reg, xs_reg;
    logic signed [15:0] cos_w, sin_w;
    logic signed [48:0] sumx, sumy, shx, shy;
    lcp_vec_t           p_reg;

    assign cos_w = $signed(rot[15:0]);
    assign sin_w = $signed(rot[31:16]);

    // floor shift of the exact rotated sums
    always_comb begin
        sumx = 49'(xc_reg) + 49'(ys_reg);
        sumy = 49'(yc_reg) - 49'(xs_reg);
        shx  = sumx >>> TRIG_SHIFT;
        shy  = sumy >>> TRIG_SHIFT;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dx_reg  <= wx - cam_x;
            dy_reg  <= wy - cam_y;
            dz_reg  <= wz - cam_z;
            xc_reg  <= 48'(dx_reg) * 48'(cos_w);
            ys_reg  <= 48'(dy_reg) * 48'(sin_w);
            yc_reg  <= 48'(dy_reg) * 48'(cos_w);
            xs_reg  <= 48'(dx_reg) * 48'(sin_w);
            dz2_reg <= dz_reg;
            p_reg.x <= shx[31:0];
            p_reg.y <= shy[31:0];
            p_reg.z <= dz2_reg;
        end
    end

    assign p = p_reg;
endmodule

FILE: rtl/core/lcp_clip.sv
// ----------------------------------------------------------------------------
// lcp_clip
// Depth clip of a segment against one plane, cutting a single crossing end.
// ----------------------------------------------------------------------------
module lcp_clip #(
    parameter bit IS_FAR = 1'b0
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  lcp_pkg::lcp_vec_t  p0,
    input  lcp_pkg::lcp_vec_t  p1,
    input  logic               drop_in,
    input  logic signed [31:0] thr,
    input  logic signed [31:0] lim,
    output lcp_pkg::lcp_vec_t  p0_out,
    output lcp_pkg::lcp_vec_t  p1_out,
    output logic               drop_out
);
    import lcp_pkg::*;

    localparam int SIDE_W = 2 * $bits(lcp_vec_t) + 3 + 32;

    logic               b0, b1, sel1;
    lcp_vec_t           av, bv;
    lcp_vec_t           a_reg, b_reg;
    logic               sel1_reg, cut_reg, drop_reg;
    logic signed [31:0] lim_reg, num_reg, den_reg, dy_reg, dz_reg;
    logic signed [31:0] md_y, md_z;
    logic [SIDE_W-1:0]  side_in, side_out;
    lcp_vec_t           a_d, b_d, na;
    logic               sel1_d, cut_d, drop_d;
    logic signed [31:0] lim_d;
    lcp_vec_t           p0_reg, p1_reg;
    logic               drop_o_reg;

    // which end lies beyond the plane
    always_comb begin
        if (IS_FAR) begin
            b0 = p0.x >= thr;
            b1 = p1.x >= thr;
        end else begin
            b0 = p0.x < thr;
            b1 = p1.x < thr;
        end
        sel1 = !b0 && b1;
        av   = sel1 ? p1 : p0;
        bv   = sel1 ? p0 : p1;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_reg    <= av;
            b_reg    <= bv;
            sel1_reg <= sel1;
            cut_reg  <= b0 || b1;
            drop_reg <= drop_in || (b0 && b1);
            lim_reg  <= lim;
            num_reg  <= lim - av.x;
            den_reg  <= bv.x - av.x;
            dy_reg   <= bv.y - av.y;
            dz_reg   <= bv.z - av.z;
        end
    end

    lcp_muldiv u_md_y (.aclk(aclk), .en(en), .a(dy_reg), .b(num_reg), .c(den_reg), .q(md_y));
    lcp_muldiv u_md_z (.aclk(aclk), .en(en), .a(dz_reg), .b(num_reg), .c(den_reg), .q(md_z));

    assign side_in = {a_reg, b_reg, sel1_reg, cut_reg, drop_reg, lim_reg};

    lcp_delay #(.W(SIDE_W), .N(MD_LAT)) u_side (
        .aclk(aclk), .aresetn(aresetn), .en(en), .din(side_in), .dout(side_out)
    );

    // move the crossing end onto the plane
    always_comb begin
        {a_d, b_d, sel1_d, cut_d, drop_d, lim_d} = side_out;
        na = a_d;
        if (cut_d) begin
            na.x = lim_d;
            na.y = a_d.y + md_y;
            na.z = a_d.z + md_z;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p0_reg     <= sel1_d ? b_d : na;
            p1_reg     <= sel1_d ? na : b_d;
            drop_o_reg <= drop_d;
        end
    end

    assign p0_out   = p0_reg;
    assign p1_out   = p1_reg;
    assign drop_out = drop_o_reg;
endmodule

FILE: rtl/core/line_clip_and_project.sv
// ----------------------------------------------------------------------------
// line_clip_and_project
// 3D segment to camera space, near/far depth clip, perspective projection.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one segment per transaction (two world endpoints and a
//   colour). m_ channel: one result per segment (visible flag on m_tuser,
//   two screen points and colour on m_tdata). A dropped segment comes out
//   with visible low and zero screen coordinates.
//   The cfg port writes camera, rotation and plane registers; write it only
//   while no segment is in flight.
//   Throughput: one segment per cycle unless m_ stalls. Both endpoint
//   lanes run side by side, and each scaled divide is a 37-stage pipeline
//   (one quotient bit a stage). Depth: 120 register stages from input to
//   result; the near clip, far clip and projection divides set that depth.
//   A stalled m_ channel freezes the whole pipeline and drops s_tready in
//   the same cycle; nothing is lost.
//   Reset clears all valid bits and loads the register reset values
//   (rotation cosine 1024, plane distance 200, half sizes 200 and 150).
// ----------------------------------------------------------------------------
module line_clip_and_project #(
    parameter int SCREEN_WIDTH  = 640,
    parameter int SCREEN_HEIGHT = 480,
    parameter int TRIG_SHIFT    = 10,
    parameter int DEPTH_UNIT    = 2
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // start_x, start_y, start_z, end_x, end_y, end_z, line_colour
    input  logic [199:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // screen_x0, screen_y0, screen_x1, screen_y1, out_colour
    output logic [135:0] m_tdata,
    // visible
    output logic         m_tuser,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data
);
    import lcp_pkg::*;

    localparam int SIDE_LAT = XFORM_LAT + 2 * CLIP_LAT + 1 + MD_LAT;
    localparam logic signed [31:0] FAR_THR = 32'(65535 * DEPTH_UNIT);
    localparam logic signed [31:0] FAR_LIM = 32'(DEPTH_UNIT * FAR_STEP);
    localparam logic signed [31:0] HALF_W  = 32'(SCREEN_WIDTH / 2);
    localparam logic signed [31:0] HALF_H  = 32'(SCREEN_HEIGHT / 2);

    logic signed [31:0] cam_x_reg, cam_y_reg, cam_z_reg;
    logic [31:0]        rot_reg;
    logic [15:0]        pd_reg, hw_reg, hh_reg;
    logic [13:0]        scroll_reg;

    logic               en;
    logic               m_tvalid_reg;
    logic [135:0]       m_tdata_reg;
    logic               m_tuser_reg;

    lcp_vec_t           cp0, cp1, np0, np1, fp0, fp1;
    logic               near_drop, far_drop, drop_d;
    logic signed [31:0] pd_s;
    logic [8:0]         side_in, side_out;

    logic [31:0]        hw0, hh0, hw1, hh1;
    logic signed [31:0] nx0_reg, nz0_reg, nx1_reg, nz1_reg;
    logic signed [31:0] dx0_reg, dz0_reg, dx1_reg, dz1_reg;
    logic signed [31:0] kx_reg, ky_reg;
    logic signed [31:0] xs0, ys0, xs1, ys1;
    logic signed [31:0] scroll_s;
    logic signed [31:0] sx0, sy0, sx1, sy1;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cam_x_reg  <= '0;
            cam_y_reg  <= '0;
            cam_z_reg  <= '0;
            rot_reg    <= 32'd1024;
            pd_reg     <= 16'd200;
            hw_reg     <= 16'd200;
            hh_reg     <= 16'd150;
            scroll_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_CAMERA_X:    cam_x_reg  <= cfg_data;
                REG_CAMERA_Y:    cam_y_reg  <= cfg_data;
                REG_CAMERA_Z:    cam_z_reg  <= cfg_data;
                REG_ROTATION:    rot_reg    <= cfg_data;
                REG_PLANE_DIST:  pd_reg     <= cfg_data[15:0];
                REG_HALF_WIDTH:  hw_reg     <= cfg_data[15:0];
                REG_HALF_HEIGHT: hh_reg     <= cfg_data[15:0];
                REG_SCROLL:      scroll_reg <= cfg_data[13:0];
                default:         ;
            endcase
        end
    end

    // whole pipeline advances unless a result is waiting
    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;
    assign pd_s     = $signed({16'd0, pd_reg});
    assign scroll_s = 32'(signed'(scroll_reg));

    // endpoint lanes
    lcp_xform #(.TRIG_SHIFT(TRIG_SHIFT)) u_xf0 (
        .aclk(aclk), .en(en),
        .wx(s_tdata[31:0]), .wy(s_tdata[63:32]), .wz(s_tdata[95:64]),
        .cam_x(cam_x_reg), .cam_y(cam_y_reg), .cam_z(cam_z_reg), .rot(rot_reg), .p(cp0)
    );
    lcp_xform #(.TRIG_SHIFT(TRIG_SHIFT)) u_xf1 (
        .aclk(aclk), .en(en),
        .wx(s_tdata[127:96]), .wy(s_tdata[159:128]), .wz(s_tdata[191:160]),
        .cam_x(cam_x_reg), .cam_y(cam_y_reg), .cam_z(cam_z_reg), .rot(rot_reg), .p(cp1)
    );

    // near plane, then far limit
    lcp_clip #(.IS_FAR(1'b0)) u_near (
        .aclk(aclk), .aresetn(aresetn), .en(en), .p0(cp0), .p1(cp1), .drop_in(1'b0),
        .thr(pd_s), .lim(pd_s), .p0_out(np0), .p1_out(np1), .drop_out(near_drop)
    );
    lcp_clip #(.IS_FAR(1'b1)) u_far (
        .aclk(aclk), .aresetn(aresetn), .en(en), .p0(np0), .p1(np1), .drop_in(near_drop),
        .thr(FAR_THR), .lim(FAR_LIM), .p0_out(fp0), .p1_out(fp1), .drop_out(far_drop)
    );

    // projection numerators and denominators
    assign hw0 = fp0.x * {16'd0, hw_reg};
    assign hh0 = fp0.x * {16'd0, hh_reg};
    assign hw1 = fp1.x * {16'd0, hw_reg};
    assign hh1 = fp1.x * {16'd0, hh_reg};

    always_ff @(posedge aclk) begin
        if (en) begin
            nx0_reg <= -fp0.y;
            nz0_reg <= fp0.z;
            nx1_reg <= -fp1.y;
            nz1_reg <= fp1.z;
            dx0_reg <= {hw0[30:0], 1'b0};
            dz0_reg <= {hh0[30:0], 1'b0};
            dx1_reg <= {hw1[30:0], 1'b0};
            dz1_reg <= {hh1[30:0], 1'b0};
            kx_reg  <= 32'(SCREEN_WIDTH) * {16'd0, pd_reg};
            ky_reg  <= 32'(SCREEN_HEIGHT) * {16'd0, pd_reg};
        end
    end

    lcp_muldiv u_md_x0 (.aclk(aclk), .en(en), .a(nx0_reg), .b(kx_reg), .c(dx0_reg), .q(xs0));
    lcp_muldiv u_md_y0 (.aclk(aclk), .en(en), .a(nz0_reg), .b(ky_reg), .c(dz0_reg), .q(ys0));
    lcp_muldiv u_md_x1 (.aclk(aclk), .en(en), .a(nx1_reg), .b(kx_reg), .c(dx1_reg), .q(xs1));
    lcp_muldiv u_md_y1 (.aclk(aclk), .en(en), .a(nz1_reg), .b(ky_reg), .c(dz1_reg), .q(ys1));

    lcp_delay #(.W(1), .N(1 + MD_LAT)) u_drop (
        .aclk(aclk), .aresetn(aresetn), .en(en), .din(far_drop), .dout(drop_d)
    );

    // transaction valid and colour ride alongside
    assign side_in = {s_tvalid && en, s_tdata[199:192]};
    lcp_delay #(.W(9), .N(SIDE_LAT)) u_side (
        .aclk(aclk), .aresetn(aresetn), .en(en), .din(side_in), .dout(side_out)
    );

    // screen offsets, zero for a dropped segment
    always_comb begin
        sx0 = drop_d ? 32'sd0 : xs0 + HALF_W;
        sy0 = drop_d ? 32'sd0 : -ys0 + HALF_H + scroll_s;
        sx1 = drop_d ? 32'sd0 : xs1 + HALF_W;
        sy1 = drop_d ? 32'sd0 : -ys1 + HALF_H + scroll_s;
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= side_out[8];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= {side_out[7:0], sy1, sx1, sy0, sx0};
            m_tuser_reg <= !drop_d;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef SYNTHESIS
    a_drop_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata[127:0] == '0))
        else $error("dropped segment carries screen coordinates");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_reset_rot: assert property (@(posedge aclk)
        !aresetn |=> (rot_reg == 32'd1024 && pd_reg == 16'd200))
        else $error("register reset values not loaded");
`endif
endmodule

FILE: bench/segment_projection_checker.sv
// ----------------------------------------------------------------------------
// segment_projection_checker
// Watches both streams and the register port of the segment clip and
// projection block. It predicts the screen result of every accepted segment
// and compares each result, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module segment_projection_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [199:0] s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [135:0] m_tdata,
    input  logic         m_tuser,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data,
    output int           fail_count,
    output int           pending
);
    import lcp_pkg::*;

    localparam int SCREEN_WIDTH  = 640;
    localparam int SCREEN_HEIGHT = 480;
    localparam int TRIG_SHIFT    = 10;
    localparam int DEPTH_UNIT    = 2;

    typedef struct {
        bit       visible;
        int       x0;
        int       y0;
        int       x1;
        int       y1;
        bit [7:0] colour;
    } screen_line_t;

    // register copy
    int        cam_x, cam_y, cam_z;
    bit [31:0] rot_words;
    int        plane_dist, half_w, half_h, scroll;

    screen_line_t expected_lines[$];
    int           errors;

    assign fail_count = errors;
    assign pending    = expected_lines.size();

    // rounded scaled divide, -1 on zero divisor or overflow
    function automatic int scaled_div(int a, int b, int c);
        longint            p;
        bit                neg;
        longint unsigned   ap, ac, q;
        if (c == 0) return -1;
        p   = longint'(a) * longint'(b);
        neg = (p < 0) != (c < 0);
        ap  = (p < 0) ? longint'(0) - p : p;
        ac  = (c < 0) ? longint'(0) - longint'(c) : longint'(c);
        q   = (ap + ac / 2) / ac;
        if (neg) begin
            if (q > 64'h8000_0000) return -1;
            return int'(longint'(0) - longint'(q));
        end
        if (q > 64'h7FFF_FFFF) return -1;
        return int'(q);
    endfunction

    function automatic lcp_vec_t world_to_camera(int wx, int wy, int wz);
        lcp_vec_t r;
        longint   cs, sn, t;
        int       dx, dy;
        cs  = longint'($signed(rot_words[15:0]));
        sn  = longint'($signed(rot_words[31:16]));
        dx  = wx - cam_x;
        dy  = wy - cam_y;
        t   = longint'(dx) * cs + longint'(dy) * sn;
        r.x = 32'(t >>> TRIG_SHIFT);
        t   = longint'(dy) * cs - longint'(dx) * sn;
        r.y = 32'(t >>> TRIG_SHIFT);
        r.z = wz - cam_z;
        return r;
    endfunction

    // slide end a along the segment until its depth equals lim
    function automatic lcp_vec_t cut_depth(lcp_vec_t a, lcp_vec_t b, int lim);
        int num, den;
        num = lim - a.x;
        den = b.x - a.x;
        a.z = a.z + scaled_div(b.z - a.z, num, den);
        a.y = a.y + scaled_div(b.y - a.y, num, den);
        a.x = lim;
        return a;
    endfunction

    function automatic screen_line_t project_segment(logic [199:0] d);
        screen_line_t r;
        lcp_vec_t     p0, p1;
        bit           b0, b1;
        int           kx, ky, far_lim;
        far_lim  = DEPTH_UNIT * FAR_STEP;
        r        = '{0, 0, 0, 0, 0, d[199:192]};
        p0 = world_to_camera(d[31:0], d[63:32], d[95:64]);
        p1 = world_to_camera(d[127:96], d[159:128], d[191:160]);
        // near plane
        b0 = p0.x < plane_dist;
        b1 = p1.x < plane_dist;
        if (b0 && b1) return r;
        if (b0) p0 = cut_depth(p0, p1, plane_dist);
        else if (b1) p1 = cut_depth(p1, p0, plane_dist);
        // far limit
        b0 = (p0.x / DEPTH_UNIT) > FAR_STEP;
        b1 = (p1.x / DEPTH_UNIT) > FAR_STEP;
        if (b0 && b1) return r;
        if (b0) p0 = cut_depth(p0, p1, far_lim);
        else if (b1) p1 = cut_depth(p1, p0, far_lim);
        // perspective
        kx = SCREEN_WIDTH * plane_dist;
        ky = SCREEN_HEIGHT * plane_dist;
        r.visible = 1'b1;
        r.x0 = scaled_div(-p0.y, kx, p0.x * half_w * 2) + SCREEN_WIDTH / 2;
        r.y0 = -scaled_div(p0.z, ky, p0.x * half_h * 2) + SCREEN_HEIGHT / 2 + scroll;
        r.x1 = scaled_div(-p1.y, kx, p1.x * half_w * 2) + SCREEN_WIDTH / 2;
        r.y1 = -scaled_div(p1.z, ky, p1.x * half_h * 2) + SCREEN_HEIGHT / 2 + scroll;
        return r;
    endfunction

    task automatic report_field(string name, longint want, longint got);
        if (errors < 10)
            $display("mismatch %s: expected %0d, got %0d", name, want, got);
        errors++;
    endtask

    always @(posedge aclk) begin
        screen_line_t want, got;
        if (!aresetn) begin
            cam_x      = 0;
            cam_y      = 0;
            cam_z      = 0;
            rot_words  = 32'd1024;
            plane_dist = 200;
            half_w     = 200;
            half_h     = 150;
            scroll     = 0;
            expected_lines.delete();
            errors     = 0;
        end else begin
            // register writes
            if (cfg_we) begin
                case (cfg_index)
                    REG_CAMERA_X:    cam_x      = cfg_data;
                    REG_CAMERA_Y:    cam_y      = cfg_data;
                    REG_CAMERA_Z:    cam_z      = cfg_data;
                    REG_ROTATION:    rot_words  = cfg_data;
                    REG_PLANE_DIST:  plane_dist = int'(cfg_data[15:0]);
                    REG_HALF_WIDTH:  half_w     = int'(cfg_data[15:0]);
                    REG_HALF_HEIGHT: half_h     = int'(cfg_data[15:0]);
                    REG_SCROLL:      scroll     = int'($signed(cfg_data[13:0]));
                    default: ;
                endcase
            end
            // input transaction
            if (s_tvalid && s_tready)
                expected_lines.push_back(project_segment(s_tdata));
            // result transaction
            if (m_tvalid && m_tready) begin
                got.visible = m_tuser;
                got.x0      = m_tdata[31:0];
                got.y0      = m_tdata[63:32];
                got.x1      = m_tdata[95:64];
                got.y1      = m_tdata[127:96];
                got.colour  = m_tdata[135:128];
                if (expected_lines.size() == 0) begin
                    if (errors < 10) $display("result with nothing expected");
                    errors++;
                end else begin
                    want = expected_lines.pop_front();
                    if (want.visible != got.visible)
                        report_field("visible", want.visible, got.visible);
                    if (want.x0 != got.x0) report_field("screen_x0", want.x0, got.x0);
                    if (want.y0 != got.y0) report_field("screen_y0", want.y0, got.y0);
                    if (want.x1 != got.x1) report_field("screen_x1", want.x1, got.x1);
                    if (want.y1 != got.y1) report_field("screen_y1", want.y1, got.y1);
                    if (want.colour != got.colour)
                        report_field("out_colour", want.colour, got.colour);
                end
            end
        end
    end

endmodule

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Segment clip and projection stimulus. Drives directed and random segments
// through several camera and plane settings, with bursty input, a stalling
// result side and one long hold-off; the checker predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
    import lcp_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_WAIT  = 150;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [199:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [135:0] m_tdata;
    logic         m_tuser;
    logic         cfg_we = 1'b0;
    logic [2:0]   cfg_index = '0;
    logic [31:0]  cfg_data = '0;

    int  fail_count, pending;
    int  cycles = 0;
    bit  hold_request = 1'b0;
    int  hold_left = 0;
    int  burst_left = 0;

    // view of the camera that random segments are placed around
    int  cam_x, cam_y, cam_z, near_depth;

    line_clip_and_project u_top (.*);

    segment_projection_checker u_checker (.*);

    // clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // run limit
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("testbench failed");
            $finish;
        end
    end

    // result side: changing stall pattern, plus one long hold-off on request
    always @(posedge aclk) begin
        if (hold_request && hold_left == 0) begin
            hold_left <= 800;
            m_tready  <= 1'b0;
        end else if (hold_left > 1) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            if (hold_left == 1) hold_left <= -1;
            case ((cycles / 500) % 3)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 1) == 1);
                default: m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
    endtask

    task automatic load_settings(int cx, int cy, int cz, logic [31:0] rot,
                                 int pd, int hw, int hh, int scr);
        write_reg(REG_CAMERA_X, cx);
        write_reg(REG_CAMERA_Y, cy);
        write_reg(REG_CAMERA_Z, cz);
        write_reg(REG_ROTATION, rot);
        write_reg(REG_PLANE_DIST, pd);
        write_reg(REG_HALF_WIDTH, hw);
        write_reg(REG_HALF_HEIGHT, hh);
        write_reg(REG_SCROLL, scr);
        cfg_we     <= 1'b0;
        cam_x      = cx;
        cam_y      = cy;
        cam_z      = cz;
        near_depth = pd;
        @(posedge aclk);
    endtask

    // one transaction, then maybe a gap at the end of a burst
    task automatic send_segment(int sx, int sy, int sz, int ex, int ey, int ez,
                                logic [7:0] colour);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {colour, ez, ey, ex, sz, sy, sx};
        do @(posedge aclk); while (!s_tready);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(1, 40);
            gap = $urandom_range(0, 12);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    function automatic int rand_span(int lo, int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    // camera-relative depth from one of several bands
    function automatic int pick_depth();
        case ($urandom_range(0, 4))
            0: return rand_span(-60000, near_depth);
            1: return rand_span(near_depth - 50, near_depth + 50);
            2: return rand_span(near_depth, 131000);
            3: return rand_span(130000, 132500);
            default: return rand_span(131000, 400000);
        endcase
    endfunction

    task automatic send_random_segment();
        if ($urandom_range(0, 9) < 2) begin
            send_segment($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                         8'($urandom));
        end else begin
            send_segment(cam_x + pick_depth(), cam_y + rand_span(-200000, 200000),
                         cam_z + rand_span(-100000, 100000),
                         cam_x + pick_depth(), cam_y + rand_span(-200000, 200000),
                         cam_z + rand_span(-100000, 100000), 8'($urandom_range(0, 255)));
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // default camera at the origin, identity rotation
        load_settings(0, 0, 0, 32'd1024, 200, 200, 150, 0);
        send_segment(0, 0, 0, 0, 0, 0, 8'h00);
        send_segment(-1, -1, -1, -1, -1, -1, 8'hFF);
        send_segment(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                     32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 8'hAA);
        send_segment(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                     32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 8'h55);
        // both behind the near plane: dropped
        send_segment(10, 5, 5, 199, -5, 3, 8'd1);
        // start beyond the far limit, end just inside it: start is cut
        send_segment(200000, 5, 5, 131069, -5, 3, 8'd2);
        // fully visible
        send_segment(1000, 300, -200, 5000, -700, 900, 8'd3);
        // start crosses near, then end crosses near
        send_segment(-500, 1000, 1000, 3000, -1000, -1000, 8'd4);
        send_segment(3000, -1000, -1000, -500, 1000, 1000, 8'd5);
        // start crosses far, end crosses far
        send_segment(500000, 9000, 9000, 1000, 10, 10, 8'd6);
        send_segment(1000, 10, 10, 500000, 9000, 9000, 8'd7);
        // crosses both planes
        send_segment(-1000, 400, 400, 900000, -400, -400, 8'd8);
        // at exactly the near and far depths
        send_segment(200, 50, 50, 131068, 50, 50, 8'd9);
        send_segment(131069, 50, 50, 131070, 50, 50, 8'd10);
        // quotient overflow gives -1
        send_segment(200, 32'h7FFF_FFFF, 32'h8000_0000, 201, 32'h8000_0000,
                     32'h7FFF_FFFF, 8'd11);
        // huge span with near cut across wrapping differences
        send_segment(32'h8000_0000, 32'h7FFF_FFFF, 0, 100000, 32'h8000_0000, 0, 8'd12);
        repeat (230) send_random_segment();
        wait_drained();

        // 45 degree turn, plane and half sizes 1, scroll -4096; long hold-off here
        load_settings(1000, -5000, 300, {16'sd724, 16'sd724}, 1, 1, 1, -4096);
        repeat (60) send_random_segment();
        hold_request <= 1'b1;
        repeat (170) send_random_segment();
        hold_request <= 1'b0;
        wait_drained();

        // extreme camera, quarter turn, maximum plane, scroll 4096
        load_settings(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h0400_0000,
                      65535, 65535, 65535, 4096);
        repeat (230) send_random_segment();
        wait_drained();

        // random register values
        load_settings($urandom, $urandom, $urandom, $urandom, rand_span(1, 65535),
                      rand_span(1, 65535), rand_span(1, 65535), rand_span(-4096, 4096));
        repeat (230) send_random_segment();
        wait_drained();

        // most negative trig words
        load_settings(-77, 12345, -9, 32'h8000_8000, 1000, 320, 240, 100);
        repeat (230) send_random_segment();
        wait_drained();

        // half turn, random plane sizes
        load_settings($urandom, $urandom, $urandom, 32'h0000_FC00, rand_span(1, 3000),
                      rand_span(1, 65535), rand_span(1, 65535), rand_span(-4096, 4096));
        repeat (230) send_random_segment();
        wait_drained();

        repeat (DRAIN_WAIT) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
